// ----- src/mic_pkg.sv -----
// Shared types and constants of the magnetometer iron correction block.
package mic_pkg;

    localparam int DIV_STAGES  = 32;
    localparam int SQRT_STAGES = 16;

    typedef enum logic [2:0] {
        CFG_LEVEL     = 3'd0,
        CFG_OFFSET_X  = 3'd1,
        CFG_OFFSET_Y  = 3'd2,
        CFG_OFFSET_Z  = 3'd3,
        CFG_ROW0      = 3'd4,
        CFG_ROW1      = 3'd5,
        CFG_ROW2      = 3'd6,
        CFG_MIN_FIELD = 3'd7
    } t_cfg_idx;

    localparam logic [2:0]  LEVEL_RST = 3'd0;
    localparam logic [59:0] ROW0_RST  = 60'h000_0000_0001_0000;
    localparam logic [59:0] ROW1_RST  = 60'h000_0010_0000_0000;
    localparam logic [59:0] ROW2_RST  = 60'h100_0000_0000_0000;
    localparam logic [15:0] MIN_RST   = 16'd960;

    typedef struct packed {
        logic signed [23:0] mag_x;
        logic signed [23:0] mag_y;
        logic signed [23:0] mag_z;
    } t_in;

    typedef struct packed {
        logic signed [23:0] field_x;
        logic signed [23:0] field_y;
        logic signed [23:0] field_z;
        logic [1:0]         accuracy;
        logic               was_scaled;
    } t_out;

    typedef struct packed {
        logic [2:0]               level;
        logic [2:0][23:0]         offset;
        logic [2:0][59:0]         row;
        logic [15:0]              min_field;
    } t_cfg;

    // unscaled result plus the signs needed when the weak-field path wins
    typedef struct packed {
        t_out       res;
        logic [2:0] neg;
    } t_side;

endpackage

// ----- src/magnetometer_iron_correction.sv -----
// Throughput: one word per cycle while the input stall is low; five front stages,
// a 32-stage divider and a 16-stage square root, all in lock step on one enable.
// The input stall is registered: it rises only when the output is stalled and
// the skid stage is full. Synchronous reset empties the pipeline and loads
// the default configuration (level 0, zero offsets, identity matrix, 960).
module magnetometer_iron_correction (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  mic_pkg::t_in      i_in_word,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output mic_pkg::t_out     o_out_word,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_addr,
    input  logic [59:0]       i_cfg_data
);

    mic_pkg::t_cfg   r_cfg;
    logic            w_en;
    logic            w_f_v, w_d_v, w_s_v;
    logic [47:0]     w_num  [3];
    logic [31:0]     w_div;
    logic [31:0]     w_quo  [3];
    logic [15:0]     w_root [3];
    mic_pkg::t_side  w_f_side, w_d_side, w_s_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.level     <= mic_pkg::LEVEL_RST;
            r_cfg.offset    <= '0;
            r_cfg.row[0]    <= mic_pkg::ROW0_RST;
            r_cfg.row[1]    <= mic_pkg::ROW1_RST;
            r_cfg.row[2]    <= mic_pkg::ROW2_RST;
            r_cfg.min_field <= mic_pkg::MIN_RST;
        end else if (i_cfg_we) begin
            unique case (mic_pkg::t_cfg_idx'(i_cfg_addr))
                mic_pkg::CFG_LEVEL:     r_cfg.level     <= i_cfg_data[2:0];
                mic_pkg::CFG_OFFSET_X:  r_cfg.offset[0] <= i_cfg_data[23:0];
                mic_pkg::CFG_OFFSET_Y:  r_cfg.offset[1] <= i_cfg_data[23:0];
                mic_pkg::CFG_OFFSET_Z:  r_cfg.offset[2] <= i_cfg_data[23:0];
                mic_pkg::CFG_ROW0:      r_cfg.row[0]    <= i_cfg_data;
                mic_pkg::CFG_ROW1:      r_cfg.row[1]    <= i_cfg_data;
                mic_pkg::CFG_ROW2:      r_cfg.row[2]    <= i_cfg_data;
                mic_pkg::CFG_MIN_FIELD: r_cfg.min_field <= i_cfg_data[15:0];
                default:                r_cfg.level     <= r_cfg.level;
            endcase
        end
    end

    mic_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_in_valid),
        .i_word  (i_in_word),
        .i_cfg   (r_cfg),
        .o_valid (w_f_v),
        .o_num   (w_num),
        .o_div   (w_div),
        .o_side  (w_f_side)
    );

    mic_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_f_v),
        .i_num   (w_num),
        .i_div   (w_div),
        .i_side  (w_f_side),
        .o_valid (w_d_v),
        .o_quo   (w_quo),
        .o_side  (w_d_side)
    );

    mic_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_d_v),
        .i_quo   (w_quo),
        .i_side  (w_d_side),
        .o_valid (w_s_v),
        .o_root  (w_root),
        .o_side  (w_s_side)
    );

    mic_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_s_v),
        .i_root  (w_root),
        .i_side  (w_s_side),
        .i_stall (i_out_stall),
        .o_en    (w_en),
        .o_valid (o_out_valid),
        .o_word  (o_out_word)
    );

    assign o_in_stall = !w_en;

endmodule

// ----- src/mic_front.sv -----
// Offset, soft-iron matrix (both bypassed at level 0), squared norm and weak-field test stages.
module mic_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  mic_pkg::t_in      i_word,
    input  mic_pkg::t_cfg     i_cfg,
    output logic              o_valid,
    output logic [47:0]       o_num [3],
    output logic [31:0]       o_div,
    output mic_pkg::t_side    o_side
);

    logic signed [23:0] w_raw [3];
    logic signed [19:0] w_k   [3][3];

    logic               r1_v, r2_v, r3_v, r4_v, r5_v;
    logic signed [23:0] r1_raw [3];
    logic signed [24:0] r1_d   [3];
    logic [2:0]         r1_lvl;
    logic signed [23:0] r2_raw [3];
    logic signed [44:0] r2_p   [3][3];
    logic [2:0]         r2_lvl;
    logic signed [30:0] r3_vec [3];
    logic [2:0]         r3_lvl;
    logic [31:0]        r4_sq  [3];
    logic [2:0]         r4_small;
    logic [2:0]         r4_neg;
    logic signed [23:0] r4_sat [3];
    logic [1:0]         r4_acc;
    logic [47:0]        r5_num [3];
    logic [31:0]        r5_div;
    mic_pkg::t_side     r5_side;

    logic signed [46:0] w_sum  [3];
    logic signed [30:0] w_vec  [3];
    logic [30:0]        w_mag  [3];
    logic [33:0]        w_norm;
    logic               w_weak;

    assign w_raw[0] = i_word.mag_x;
    assign w_raw[1] = i_word.mag_y;
    assign w_raw[2] = i_word.mag_z;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                w_k[r][c] = i_cfg.row[r][c*20 +: 20];
            end
        end
    end

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            w_sum[r] = 47'(r2_p[r][0]) + 47'(r2_p[r][1]) + 47'(r2_p[r][2])
                       + 47'sd32768;
            w_vec[r] = (r2_lvl == 3'd0) ? 31'(r2_raw[r]) : w_sum[r][46:16];
        end
    end

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_mag[a] = r3_vec[a][30] ? 31'(-r3_vec[a]) : 31'(r3_vec[a]);
        end
    end

    assign w_norm = 34'(r4_sq[0]) + 34'(r4_sq[1]) + 34'(r4_sq[2]);
    assign w_weak = (&r4_small) && (w_norm != 34'd0)
                    && (w_norm < {2'b00, i_cfg.min_field, 16'h0000});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int a = 0; a < 3; a++) begin
                r1_raw[a] <= w_raw[a];
                r1_d[a]   <= 25'(w_raw[a]) - 25'($signed(i_cfg.offset[a]));
            end
            r1_lvl <= i_cfg.level;

            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r2_p[r][c] <= w_k[r][c] * r1_d[c];
                end
                r2_raw[r] <= r1_raw[r];
            end
            r2_lvl <= r1_lvl;

            for (int r = 0; r < 3; r++) begin
                r3_vec[r] <= w_vec[r];
            end
            r3_lvl <= r2_lvl;

            for (int a = 0; a < 3; a++) begin
                r4_sq[a]    <= w_mag[a][15:0] * w_mag[a][15:0];
                r4_small[a] <= (w_mag[a][30:16] == 15'd0);
                r4_neg[a]   <= r3_vec[a][30];
                if (r3_vec[a] > 31'sd8388607) begin
                    r4_sat[a] <= 24'sh7FFFFF;
                end else if (r3_vec[a] < -31'sd8388608) begin
                    r4_sat[a] <= -24'sh800000;
                end else begin
                    r4_sat[a] <= r3_vec[a][23:0];
                end
            end
            r4_acc <= (r3_lvl >= 3'd3) ? 2'd3 : r3_lvl[1:0];

            for (int a = 0; a < 3; a++) begin
                r5_num[a] <= r4_sq[a] * i_cfg.min_field;
            end
            r5_div                 <= w_norm[31:0];
            r5_side.res.field_x    <= r4_sat[0];
            r5_side.res.field_y    <= r4_sat[1];
            r5_side.res.field_z    <= r4_sat[2];
            r5_side.res.accuracy   <= r4_acc;
            r5_side.res.was_scaled <= w_weak;
            r5_side.neg            <= r4_neg;
        end
    end

    assign o_valid = r5_v;
    assign o_num   = r5_num;
    assign o_div   = r5_div;
    assign o_side  = r5_side;

endmodule

// ----- src/mic_div.sv -----
// Three-lane restoring divider, one quotient bit per stage.
module mic_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [47:0]       i_num [3],
    input  logic [31:0]       i_div,
    input  mic_pkg::t_side    i_side,
    output logic              o_valid,
    output logic [31:0]       o_quo [3],
    output mic_pkg::t_side    o_side
);

    localparam int N = mic_pkg::DIV_STAGES;

    logic [N-1:0]    r_v;
    logic [31:0]     r_rem  [N][3];
    logic [31:0]     r_nq   [N][3];
    logic [31:0]     r_dvs  [N];
    mic_pkg::t_side  r_side [N];

    for (genvar s = 0; s < N; s++) begin : g_stage
        logic           w_v;
        logic [31:0]    w_rem [3];
        logic [31:0]    w_nq  [3];
        logic [31:0]    w_dvs;
        mic_pkg::t_side w_side;
        logic [32:0]    w_t   [3];
        logic           w_ge  [3];

        if (s == 0) begin : g_head
            assign w_v    = i_valid;
            assign w_dvs  = i_div;
            assign w_side = i_side;
            for (genvar a = 0; a < 3; a++) begin : g_lane
                assign w_rem[a] = i_num[a][47:16];
                assign w_nq[a]  = {i_num[a][15:0], 16'h0000};
            end
        end else begin : g_body
            assign w_v    = r_v[s-1];
            assign w_dvs  = r_dvs[s-1];
            assign w_side = r_side[s-1];
            for (genvar a = 0; a < 3; a++) begin : g_lane
                assign w_rem[a] = r_rem[s-1][a];
                assign w_nq[a]  = r_nq[s-1][a];
            end
        end

        always_comb begin
            for (int a = 0; a < 3; a++) begin
                w_t[a]  = {w_rem[a], w_nq[a][31]};
                w_ge[a] = (w_t[a] >= {1'b0, w_dvs});
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (i_en) begin
                r_v[s] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int a = 0; a < 3; a++) begin
                    r_rem[s][a] <= w_ge[a] ? 32'(w_t[a] - {1'b0, w_dvs}) : w_t[a][31:0];
                    r_nq[s][a]  <= {w_nq[a][30:0], w_ge[a]};
                end
                r_dvs[s]  <= w_dvs;
                r_side[s] <= w_side;
            end
        end
    end

    assign o_valid = r_v[N-1];
    assign o_quo   = r_nq[N-1];
    assign o_side  = r_side[N-1];

endmodule

// ----- src/mic_sqrt.sv -----
// Three-lane digit-by-digit square root, one root bit per stage.
module mic_sqrt (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [31:0]       i_quo [3],
    input  mic_pkg::t_side    i_side,
    output logic              o_valid,
    output logic [15:0]       o_root [3],
    output mic_pkg::t_side    o_side
);

    localparam int N = mic_pkg::SQRT_STAGES;

    logic [N-1:0]    r_v;
    logic [17:0]     r_rem  [N][3];
    logic [15:0]     r_root [N][3];
    logic [31:0]     r_qr   [N][3];
    mic_pkg::t_side  r_side [N];

    for (genvar s = 0; s < N; s++) begin : g_stage
        logic           w_v;
        logic [17:0]    w_rem  [3];
        logic [15:0]    w_root [3];
        logic [31:0]    w_qr   [3];
        mic_pkg::t_side w_side;
        logic [19:0]    w_t    [3];
        logic [19:0]    w_try  [3];
        logic           w_ge   [3];

        if (s == 0) begin : g_head
            assign w_v    = i_valid;
            assign w_side = i_side;
            for (genvar a = 0; a < 3; a++) begin : g_lane
                assign w_rem[a]  = 18'd0;
                assign w_root[a] = 16'd0;
                assign w_qr[a]   = i_quo[a];
            end
        end else begin : g_body
            assign w_v    = r_v[s-1];
            assign w_side = r_side[s-1];
            for (genvar a = 0; a < 3; a++) begin : g_lane
                assign w_rem[a]  = r_rem[s-1][a];
                assign w_root[a] = r_root[s-1][a];
                assign w_qr[a]   = r_qr[s-1][a];
            end
        end

        always_comb begin
            for (int a = 0; a < 3; a++) begin
                w_t[a]   = {w_rem[a], w_qr[a][31:30]};
                w_try[a] = {2'b00, w_root[a], 2'b01};
                w_ge[a]  = (w_t[a] >= w_try[a]);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (i_en) begin
                r_v[s] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int a = 0; a < 3; a++) begin
                    r_rem[s][a]  <= w_ge[a] ? 18'(w_t[a] - w_try[a]) : w_t[a][17:0];
                    r_root[s][a] <= {w_root[a][14:0], w_ge[a]};
                    r_qr[s][a]   <= {w_qr[a][29:0], 2'b00};
                end
                r_side[s] <= w_side;
            end
        end
    end

    assign o_valid = r_v[N-1];
    assign o_root  = r_root[N-1];
    assign o_side  = r_side[N-1];

endmodule

// ----- src/mic_out.sv -----
// Result assembly, output register and skid stage.
module mic_out (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [15:0]       i_root [3],
    input  mic_pkg::t_side    i_side,
    input  logic              i_stall,
    output logic              o_en,
    output logic              o_valid,
    output mic_pkg::t_out     o_word
);

    logic           r_out_v, r_skd_v;
    mic_pkg::t_out  r_out, r_skd;
    mic_pkg::t_out  w_new;
    logic [23:0]    w_mag [3];
    logic [23:0]    w_fld [3];
    logic           w_fire;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_mag[a] = {8'h00, i_root[a]};
            w_fld[a] = i_side.neg[a] ? 24'(24'd0 - w_mag[a]) : w_mag[a];
        end
        w_new = i_side.res;
        if (i_side.res.was_scaled) begin
            w_new.field_x = w_fld[0];
            w_new.field_y = w_fld[1];
            w_new.field_z = w_fld[2];
        end
    end

    assign w_fire = r_out_v && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
            r_skd_v <= 1'b0;
        end else if (r_skd_v) begin
            if (w_fire) begin
                r_skd_v <= 1'b0;
            end
        end else if (i_valid) begin
            if (!r_out_v || w_fire) begin
                r_out_v <= 1'b1;
            end else begin
                r_skd_v <= 1'b1;
            end
        end else if (w_fire) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skd_v) begin
            if (w_fire) begin
                r_out <= r_skd;
            end
        end else if (i_valid) begin
            if (!r_out_v || w_fire) begin
                r_out <= w_new;
            end else begin
                r_skd <= w_new;
            end
        end
    end

    assign o_en    = !r_skd_v;
    assign o_valid = r_out_v;
    assign o_word  = r_out;

endmodule

// ----- src/mic_chk.sv -----
// Port-level checks of the magnetometer iron correction block, bound to the top.
module mic_chk (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              o_in_stall,
    input  logic              o_out_valid,
    input  logic              i_out_stall,
    input  mic_pkg::t_out     o_out_word
);

    a_stalled_word_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("output word changed while stalled");

    a_stall_only_on_back_pressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_in_stall) |-> $past(o_out_valid && i_out_stall))
        else $error("input stall raised without output back pressure");

    a_scaled_small: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.was_scaled |->
            (o_out_word.field_x <= 24'sd65535) && (o_out_word.field_x >= -24'sd65535)
            && (o_out_word.field_y <= 24'sd65535) && (o_out_word.field_y >= -24'sd65535)
            && (o_out_word.field_z <= 24'sd65535) && (o_out_word.field_z >= -24'sd65535))
        else $error("scaled word out of range");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("pipeline not empty after reset");

endmodule

bind magnetometer_iron_correction mic_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);
